// File: sv/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// Used by gha_controller, gha_datapath and generational_handle_allocator.
package gha_pkg;

    localparam int SLOT_COUNT   = 256;
    localparam int IDX_BITS     = $clog2(SLOT_COUNT);
    localparam int CNT_BITS     = $clog2(SLOT_COUNT + 1);
    localparam int GEN_BITS     = 16;
    localparam int KIND_BITS    = 8;
    localparam int PAYLOAD_BITS = 32;
    localparam int REQ_BITS     = 2;
    localparam int STATUS_BITS  = 2;

    // input beat: index, generation, kind, payload from bit 0 up
    localparam int IN_BITS      = IDX_BITS + GEN_BITS + KIND_BITS + PAYLOAD_BITS;
    localparam int S_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;

    // output beat: status, index, generation, kind, payload, live count
    localparam int RES_BITS     = STATUS_BITS + IDX_BITS + GEN_BITS + KIND_BITS
                                  + PAYLOAD_BITS + CNT_BITS;
    localparam int M_TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    // beat widths for a given table geometry, padded to whole bytes
    function automatic int s_tdata_width(int slots, int gen_w, int kind_w, int pay_w);
        return (($clog2(slots) + gen_w + kind_w + pay_w + 7) / 8) * 8;
    endfunction

    function automatic int m_tdata_width(int slots, int gen_w, int kind_w, int pay_w);
        return ((STATUS_BITS + $clog2(slots) + gen_w + kind_w + pay_w
                 + $clog2(slots + 1) + 7) / 8) * 8;
    endfunction

    typedef enum logic [REQ_BITS-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_UPDATE  = 2'd3
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK        = 2'd0,
        STS_KIND_NONE = 2'd1,
        STS_FULL      = 2'd2,
        STS_STALE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_FAIL_KIND,
        OP_FAIL_FULL,
        OP_FRESH,
        OP_POP,
        OP_HANDLE
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_EXEC_POP,
        ST_EXEC_HDL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;    // latch the input beat
        logic rd_stack;   // read free stack top
        logic rd_handle;  // read slot memories at the handle index
        logic rd_pop;     // read slot memories at the popped index
        logic exec;       // commit op and load the result
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic kind_zero;
        logic stack_empty;
        logic table_full;
    } dp_status_t;

endpackage

// File: sv/gha_controller.sv
// Request sequencer for the generational handle allocator.
// Depends on gha_pkg; drives the datapath through cmd_t and reads dp_status_t.
module gha_controller
    import gha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t dp_sts,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{capture: 1'b0, rd_stack: 1'b0, rd_handle: 1'b0, rd_pop: 1'b0,
                       exec: 1'b0, op: OP_HANDLE};
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!dp_sts.is_alloc)
                begin
                    cmd.rd_handle = 1'b1;
                    state_next    = ST_EXEC_HDL;
                end
                else if (dp_sts.kind_zero)
                begin
                    cmd.exec   = 1'b1;
                    cmd.op     = OP_FAIL_KIND;
                    state_next = ST_RESP;
                end
                else if (!dp_sts.stack_empty)
                begin
                    cmd.rd_stack = 1'b1;
                    state_next   = ST_POP;
                end
                else if (dp_sts.table_full)
                begin
                    cmd.exec   = 1'b1;
                    cmd.op     = OP_FAIL_FULL;
                    state_next = ST_RESP;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    cmd.op     = OP_FRESH;
                    state_next = ST_RESP;
                end
            end
            ST_POP:
            begin
                cmd.rd_pop = 1'b1;
                state_next = ST_EXEC_POP;
            end
            ST_EXEC_POP:
            begin
                cmd.exec   = 1'b1;
                cmd.op     = OP_POP;
                state_next = ST_RESP;
            end
            ST_EXEC_HDL:
            begin
                cmd.exec   = 1'b1;
                cmd.op     = OP_HANDLE;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/gha_datapath.sv
// Slot table, free stack, counters and result register of the handle allocator.
// Depends on gha_pkg; sequenced by gha_controller through cmd_t.
module gha_datapath
    import gha_pkg::*;
#(
    parameter int SLOTS  = SLOT_COUNT,
    parameter int GEN_W  = GEN_BITS,
    parameter int KIND_W = KIND_BITS,
    parameter int PAY_W  = PAYLOAD_BITS
)
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic [REQ_BITS-1:0]                                   in_user,
    input  logic [s_tdata_width(SLOTS, GEN_W, KIND_W, PAY_W)-1:0] in_data,
    input  cmd_t                                                  cmd,
    output dp_status_t                                            dp_sts,
    output logic [m_tdata_width(SLOTS, GEN_W, KIND_W, PAY_W)-1:0] out_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int RES_W = STATUS_BITS + IDX_W + GEN_W + KIND_W + PAY_W + CNT_W;
    localparam int OUT_W = m_tdata_width(SLOTS, GEN_W, KIND_W, PAY_W);

    // latched request
    req_t                req_type_reg;
    logic [IDX_W-1:0]    req_idx_reg;
    logic [GEN_W-1:0]    req_gen_reg;
    logic [KIND_W-1:0]   req_kind_reg;
    logic [PAY_W-1:0]    req_val_reg;

    // table state
    logic [CNT_W-1:0]    free_depth_reg, free_depth_next;
    logic [CNT_W-1:0]    mark_reg, mark_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [IDX_W-1:0]    slot_reg;

    // alive flags are only checked below the mark, where they have been written
    logic                alive_mem [SLOTS];
    logic [GEN_W-1:0]    gen_mem   [SLOTS];
    logic [KIND_W-1:0]   kind_mem  [SLOTS];
    logic [PAY_W-1:0]    pay_mem   [SLOTS];
    logic [IDX_W-1:0]    stack_mem [SLOTS];

    logic                alive_rd_reg;
    logic [GEN_W-1:0]    gen_rd_reg;
    logic [KIND_W-1:0]   kind_rd_reg;
    logic [PAY_W-1:0]    pay_rd_reg;
    logic [IDX_W-1:0]    stack_rd_reg;

    // result
    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [GEN_W-1:0]    res_gen_reg, res_gen_next;
    logic [KIND_W-1:0]   res_kind_reg, res_kind_next;
    logic [PAY_W-1:0]    res_dense_reg, res_dense_next;
    logic [CNT_W-1:0]    res_live_reg;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    depth_dec;
    logic [IDX_W-1:0]    eff_slot;
    logic                hdl_ok;
    logic [GEN_W-1:0]    gen_inc;
    logic [GEN_W-1:0]    gen_wdata;
    logic [KIND_W-1:0]   kind_wdata;
    logic [PAY_W-1:0]    pay_wdata;
    logic                gen_we, kind_we, pay_we, stk_we;
    logic                alive_we, alive_wdata;

    assign dp_sts.is_alloc    = (req_type_reg == REQ_ALLOC);
    assign dp_sts.kind_zero   = (req_kind_reg == '0);
    assign dp_sts.stack_empty = (free_depth_reg == '0);
    assign dp_sts.table_full  = (mark_reg == CNT_W'(SLOTS));

    assign rd_en     = cmd.rd_handle | cmd.rd_pop;
    assign rd_addr   = cmd.rd_pop ? stack_rd_reg : req_idx_reg;
    assign depth_dec = free_depth_reg - CNT_W'(1);
    assign eff_slot  = (cmd.op == OP_FRESH) ? mark_reg[IDX_W-1:0] : slot_reg;

    // slot_reg equals the handle index during the handle execute cycle
    assign hdl_ok = (req_gen_reg != '0)
                    && (CNT_W'(req_idx_reg) < mark_reg)
                    && alive_rd_reg
                    && (gen_rd_reg == req_gen_reg);

    // generation advances and skips zero
    assign gen_inc = (gen_rd_reg + GEN_W'(1) == '0) ? GEN_W'(1)
                                                     : gen_rd_reg + GEN_W'(1);

    always_comb
    begin
        free_depth_next = free_depth_reg;
        mark_next       = mark_reg;
        total_next      = total_reg;
        gen_we          = 1'b0;
        kind_we         = 1'b0;
        pay_we          = 1'b0;
        stk_we          = 1'b0;
        alive_we        = 1'b0;
        alive_wdata     = 1'b1;
        gen_wdata       = GEN_W'(1);
        kind_wdata      = req_kind_reg;
        pay_wdata       = req_val_reg;
        res_status_next = STS_OK;
        res_idx_next    = '0;
        res_gen_next    = '0;
        res_kind_next   = '0;
        res_dense_next  = '0;
        if (cmd.exec)
        begin
            case (cmd.op)
                OP_FAIL_KIND:
                begin
                    res_status_next = STS_KIND_NONE;
                end
                OP_FAIL_FULL:
                begin
                    res_status_next = STS_FULL;
                end
                OP_FRESH:
                begin
                    gen_we       = 1'b1;
                    kind_we      = 1'b1;
                    pay_we       = 1'b1;
                    alive_we     = 1'b1;
                    mark_next    = mark_reg + CNT_W'(1);
                    total_next   = total_reg + CNT_W'(1);
                    res_idx_next = eff_slot;
                    res_gen_next = GEN_W'(1);
                end
                OP_POP:
                begin
                    kind_we         = 1'b1;
                    pay_we          = 1'b1;
                    alive_we        = 1'b1;
                    free_depth_next = depth_dec;
                    total_next      = total_reg + CNT_W'(1);
                    res_idx_next    = eff_slot;
                    res_gen_next    = gen_rd_reg;
                end
                OP_HANDLE:
                begin
                    if (!hdl_ok)
                    begin
                        res_status_next = STS_STALE;
                        if (req_type_reg == REQ_QUERY)
                        begin
                            res_dense_next = '1;
                        end
                    end
                    else
                    begin
                        case (req_type_reg)
                            REQ_RELEASE:
                            begin
                                gen_we      = 1'b1;
                                gen_wdata   = gen_inc;
                                kind_we     = 1'b1;
                                kind_wdata  = '0;
                                pay_we      = 1'b1;
                                pay_wdata   = '0;
                                alive_we    = 1'b1;
                                alive_wdata = 1'b0;
                                if (free_depth_reg < CNT_W'(SLOTS))
                                begin
                                    stk_we          = 1'b1;
                                    free_depth_next = free_depth_reg + CNT_W'(1);
                                end
                                if (total_reg != '0)
                                begin
                                    total_next = total_reg - CNT_W'(1);
                                end
                            end
                            REQ_QUERY:
                            begin
                                res_kind_next  = kind_rd_reg;
                                res_dense_next = pay_rd_reg;
                            end
                            REQ_UPDATE:
                            begin
                                pay_we = 1'b1;
                            end
                            default:
                            begin
                                res_status_next = STS_OK;
                            end
                        endcase
                    end
                end
                default:
                begin
                    res_status_next = STS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_t'(in_user);
            req_idx_reg  <= in_data[IDX_W-1:0];
            req_gen_reg  <= in_data[IDX_W +: GEN_W];
            req_kind_reg <= in_data[IDX_W+GEN_W +: KIND_W];
            req_val_reg  <= in_data[IDX_W+GEN_W+KIND_W +: PAY_W];
        end
        if (rd_en)
        begin
            slot_reg <= rd_addr;
        end
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
            res_gen_reg    <= res_gen_next;
            res_kind_reg   <= res_kind_next;
            res_dense_reg  <= res_dense_next;
            res_live_reg   <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_depth_reg <= '0;
            mark_reg       <= '0;
            total_reg      <= '0;
        end
        else
        begin
            free_depth_reg <= free_depth_next;
            mark_reg       <= mark_next;
            total_reg      <= total_next;
        end
    end

    // slot memories: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (alive_we)
        begin
            alive_mem[eff_slot] <= alive_wdata;
        end
        if (rd_en)
        begin
            alive_rd_reg <= alive_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[eff_slot] <= gen_wdata;
        end
        if (rd_en)
        begin
            gen_rd_reg <= gen_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (kind_we)
        begin
            kind_mem[eff_slot] <= kind_wdata;
        end
        if (rd_en)
        begin
            kind_rd_reg <= kind_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[eff_slot] <= pay_wdata;
        end
        if (rd_en)
        begin
            pay_rd_reg <= pay_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[free_depth_reg[IDX_W-1:0]] <= eff_slot;
        end
        if (cmd.rd_stack)
        begin
            stack_rd_reg <= stack_mem[depth_dec[IDX_W-1:0]];
        end
    end

    // zero pad above the result fields
    assign out_data = OUT_W'({res_live_reg, res_dense_reg, res_kind_reg, res_gen_reg,
                              res_idx_reg, res_status_reg});

endmodule

// File: sv/generational_handle_allocator.sv
// Generational handle allocator: slot table with generation-checked handles.
// Top level; instantiates gha_controller and gha_datapath, uses gha_pkg.
//
// Requests arrive on the s_ channel, one beat each; s_tuser carries the request
// type (allocate, release, query, update). Every request returns exactly one
// beat on the m_ channel with status, allocated handle, queried kind/payload
// and the live slot count after the request.
// One request is in flight at a time. s_tready is high only while idle.
// From input beat to result beat, a fresh or failed allocate is executed in
// the decode state; query, update and release pass through an execute state
// after the registered read of the slot; an allocate that reuses a freed slot
// waits on the registered reads of the free stack and then of the slot's
// generation memory before it is executed.
// A result is held on m_tdata with m_tvalid high until m_tready; no new
// request is taken meanwhile.
// Reset empties the table: no slot alive, free stack empty, nothing handed
// out; the slot memories need no clearing and reset takes effect at once.
module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int SLOTS  = SLOT_COUNT,
    parameter int GEN_W  = GEN_BITS,
    parameter int KIND_W = KIND_BITS,
    parameter int PAY_W  = PAYLOAD_BITS
)
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // handle_index, handle_generation, entity_kind, dense_value
    input  logic [s_tdata_width(SLOTS, GEN_W, KIND_W, PAY_W)-1:0] s_tdata,
    // req_type
    input  logic [REQ_BITS-1:0]                                   s_tuser,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // status, out_index, out_generation, out_kind, out_dense, live_count, zero pad
    output logic [m_tdata_width(SLOTS, GEN_W, KIND_W, PAY_W)-1:0] m_tdata
);

    cmd_t       cmd;
    dp_status_t dp_sts;

    gha_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_sts   (dp_sts),
        .cmd      (cmd)
    );

    gha_datapath #(
        .SLOTS  (SLOTS),
        .GEN_W  (GEN_W),
        .KIND_W (KIND_W),
        .PAY_W  (PAY_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_user  (s_tuser),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .dp_sts   (dp_sts),
        .out_data (m_tdata)
    );

endmodule
